@@ rtl/core/osc52b64_pkg.sv @@
// Shared types, constants and character tables of the OSC 52 base64 framer.
package osc52b64_pkg;

  // What the encoder must send for one group of input bytes
  typedef enum logic [1:0] {
    GRP_NONE = 2'd0,  // nothing to encode
    GRP_FULL = 2'd1,  // four sextet characters
    GRP_ONE  = 2'd2,  // one byte held: two characters, two pads
    GRP_TWO  = 2'd3   // two bytes held: three characters, one pad
  } grp_t;

  // One command from front to back
  typedef struct packed {
    logic        prefix;  // send ESC ] 5 2 ; c ;
    grp_t        grp;
    logic [23:0] bits;    // 24-bit group, first byte in the top bits
    logic        bel;     // close the sequence
  } cmd_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef logic [3:0] slot_t;
  localparam slot_t SLOT_PRE_FIRST = 4'd0;
  localparam slot_t SLOT_PRE_LAST  = 4'd6;
  localparam slot_t SLOT_GRP_FIRST = 4'd7;
  localparam slot_t SLOT_GRP_LAST  = 4'd10;
  localparam slot_t SLOT_BEL       = 4'd11;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] BEL_CHAR = 8'h07;

  // Standard base64 alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx inside {[6'd0 : 6'd25]}) begin
      ch = 8'h41 + {2'b00, idx};
    end else if (idx inside {[6'd26 : 6'd51]}) begin
      ch = 8'h61 + {2'b00, idx} - 8'd26;
    end else if (idx inside {[6'd52 : 6'd61]}) begin
      ch = 8'h30 + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

  // ESC ] 5 2 ; c ;
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (pos)
      3'd0:    ch = 8'h1B;
      3'd1:    ch = 8'h5D;
      3'd2:    ch = 8'h35;
      3'd3:    ch = 8'h32;
      3'd4:    ch = 8'h3B;
      3'd5:    ch = 8'h63;
      3'd6:    ch = 8'h3B;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/osc52b64_front.sv @@
// Front end: accepts bytes, tracks the group and message state, issues commands.
module osc52b64_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  logic [7:0]           data_byte,
  input  logic                 final_byte,
  input  logic                 q_full,
  output logic                 push,
  output osc52b64_pkg::cmd_t   push_cmd
);
  import osc52b64_pkg::*;

  logic [1:0]  group_position, group_position_next;
  logic [15:0] held_bytes, held_bytes_next;
  logic        inside_message, inside_message_next;
  logic        accept;
  logic [1:0]  pos;
  logic [15:0] held;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    // A new message starts from an empty group
    pos  = inside_message ? group_position : 2'd0;
    held = inside_message ? held_bytes : 16'd0;

    push_cmd.prefix     = !inside_message;
    push_cmd.grp        = GRP_NONE;
    push_cmd.bits       = 24'd0;
    push_cmd.bel        = final_byte;
    group_position_next = pos;
    held_bytes_next     = held;
    inside_message_next = 1'b1;

    case (pos)
      2'd0: begin
        held_bytes_next     = {data_byte, 8'h00};
        group_position_next = 2'd1;
      end
      2'd1: begin
        held_bytes_next     = {held[15:8], data_byte};
        group_position_next = 2'd2;
      end
      default: begin
        push_cmd.grp        = GRP_FULL;
        push_cmd.bits       = {held, data_byte};
        held_bytes_next     = 16'd0;
        group_position_next = 2'd0;
      end
    endcase

    if (final_byte) begin
      if (group_position_next == 2'd1) begin
        push_cmd.grp  = GRP_ONE;
        push_cmd.bits = {held_bytes_next, 8'h00};
      end else if (group_position_next == 2'd2) begin
        push_cmd.grp  = GRP_TWO;
        push_cmd.bits = {held_bytes_next, 8'h00};
      end
      group_position_next = 2'd0;
      held_bytes_next     = 16'd0;
      inside_message_next = 1'b0;
    end

    // Drop bytes that only fill the group
    push = accept && (push_cmd.prefix || (push_cmd.grp != GRP_NONE) || push_cmd.bel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      held_bytes     <= 16'd0;
      inside_message <= 1'b0;
    end else if (accept) begin
      group_position <= group_position_next;
      held_bytes     <= held_bytes_next;
      inside_message <= inside_message_next;
    end
  end

endmodule

@@ rtl/core/osc52b64_queue.sv @@
// Short command queue between the front and back ends.
module osc52b64_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  osc52b64_pkg::cmd_t   push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output osc52b64_pkg::cmd_t   q_cmd
);
  import osc52b64_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full    = (count == QCW'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
`endif

endmodule

@@ rtl/core/osc52b64_back.sv @@
// Back end: walks each command's character slots and drives the output register.
module osc52b64_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  osc52b64_pkg::cmd_t   q_cmd,
  output logic                 pop,
  output logic                 char_valid,
  input  logic                 char_ready,
  output logic [7:0]           out_char,
  output logic                 run_last,
  output logic                 sequence_end
);
  import osc52b64_pkg::*;

  cmd_t       cur;
  slot_t      slot;
  logic       busy;
  logic       out_free;
  logic       emit;
  logic       last;
  logic [7:0] ch;
  logic [1:0] k;

  function automatic slot_t first_slot(input cmd_t c);
    slot_t s;
    if (c.prefix) begin
      s = SLOT_PRE_FIRST;
    end else if (c.grp != GRP_NONE) begin
      s = SLOT_GRP_FIRST;
    end else begin
      s = SLOT_BEL;
    end
    return s;
  endfunction

  function automatic logic has_next(input cmd_t c, input slot_t s);
    logic r;
    if (s < SLOT_PRE_LAST) begin
      r = 1'b1;
    end else if (s == SLOT_PRE_LAST) begin
      r = (c.grp != GRP_NONE) || c.bel;
    end else if (s < SLOT_GRP_LAST) begin
      r = 1'b1;
    end else if (s == SLOT_GRP_LAST) begin
      r = c.bel;
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

  assign out_free = !char_valid || char_ready;
  assign emit     = busy && out_free;
  assign last     = !has_next(cur, slot);
  assign pop      = q_valid && (!busy || (emit && last));
  assign k        = 2'(slot - SLOT_GRP_FIRST);

  always_comb begin
    ch = BEL_CHAR;
    if (slot <= SLOT_PRE_LAST) begin
      ch = prefix_char(slot[2:0]);
    end else if (slot <= SLOT_GRP_LAST) begin
      if ((cur.grp == GRP_ONE && k[1]) || (cur.grp == GRP_TWO && k == 2'd3)) begin
        ch = PAD_CHAR;
      end else begin
        case (k)
          2'd0:    ch = b64_char(cur.bits[23:18]);
          2'd1:    ch = b64_char(cur.bits[17:12]);
          2'd2:    ch = b64_char(cur.bits[11:6]);
          default: ch = b64_char(cur.bits[5:0]);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (out_free) begin
        char_valid <= emit;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char     <= ch;
      run_last     <= last;
      sequence_end <= (slot == SLOT_BEL);
    end
    if (pop) begin
      cur  <= q_cmd;
      slot <= first_slot(q_cmd);
    end else if (emit && !last) begin
      slot <= (slot == SLOT_PRE_LAST && cur.grp == GRP_NONE) ? SLOT_BEL : slot + 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
      char_valid && sequence_end |-> run_last)
    else $error("terminator not marked as last character of its byte");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
      busy |-> slot <= SLOT_BEL)
    else $error("slot out of range");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
      char_valid && !char_ready |=> char_valid && $stable(out_char))
    else $error("output character changed under stall");
`endif

endmodule

@@ rtl/core/osc52_base64_clipboard_framer_unit.sv @@
// Top level of the OSC 52 clipboard framer with base64 encoding.
//
// Input channel: one raw message byte per item on data_byte, with final_byte
// set on the last byte of the message. Output channel: one ASCII character
// per item on out_char; run_last marks the last character caused by an input
// byte, sequence_end marks the closing BEL.
// The first byte of a message makes the block send ESC ] 5 2 ; c ; ahead of
// the text. Every third byte releases four base64 characters; the final byte
// flushes a partial group with '=' padding and then BEL.
// An accepted byte's command passes through the queue entry, the back end's
// command register and the output register. The back end sends one character
// per cycle while the receiver is ready; bytes that only fill a group push no
// command. A two-entry command queue between front and back lets the input
// keep flowing while characters drain.
// Reset clears the message state, the queue and the output valid flag.
// When the receiver stalls, the output item holds, the queue fills, and then
// byte_ready drops until the back end frees a queue entry.
module osc52_base64_clipboard_framer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       char_valid,
  input  logic       char_ready,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       sequence_end
);
  import osc52b64_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t q_cmd;

  // Classify each byte into a command
  osc52b64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Hold commands while the back end drains characters
  osc52b64_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Expand each command into characters, one per cycle while the receiver is ready
  osc52b64_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .out_char     (out_char),
    .run_last     (run_last),
    .sequence_end (sequence_end)
  );

endmodule

@@ tb/osc52_seq_checker.sv @@
// Watches both channels of the OSC 52 framer, predicts each character and compares.
module osc52_seq_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       char_valid,
  input  logic       char_ready,
  input  logic [7:0] out_char,
  input  logic       run_last,
  input  logic       sequence_end,
  output int         fail_count,
  output int         chars_pending,
  output int         chars_checked
);
  import osc52b64_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       seq_end;
  } seq_char_t;

  localparam logic [511:0] SEXTET_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [55:0] OSC_PREFIX = {8'h1B, "]52;c;"};

  seq_char_t   want_chars[$];
  logic [1:0]  grp_pos;
  logic [15:0] held;
  logic        in_msg;

  function automatic logic [7:0] b64_of(input logic [5:0] v);
    return SEXTET_CHARS[8*(63 - int'(v)) +: 8];
  endfunction

  // Work out every character one accepted byte causes and queue them in order.
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    seq_char_t   run[12];
    int          n;
    logic [23:0] grp;
    n = 0;
    if (!in_msg) begin
      for (int i = 0; i < 7; i++) begin
        run[n] = '{OSC_PREFIX[8*(6 - i) +: 8], 1'b0, 1'b0};
        n++;
      end
      in_msg  = 1'b1;
      grp_pos = 2'd0;
      held    = '0;
    end
    case (grp_pos)
      2'd0: begin
        held    = {b, 8'h00};
        grp_pos = 2'd1;
      end
      2'd1: begin
        held[7:0] = b;
        grp_pos   = 2'd2;
      end
      default: begin
        grp = {held, b};
        run[n]     = '{b64_of(grp[23:18]), 1'b0, 1'b0};
        run[n + 1] = '{b64_of(grp[17:12]), 1'b0, 1'b0};
        run[n + 2] = '{b64_of(grp[11:6]), 1'b0, 1'b0};
        run[n + 3] = '{b64_of(grp[5:0]), 1'b0, 1'b0};
        n += 4;
        grp_pos = 2'd0;
        held    = '0;
      end
    endcase
    if (fin) begin
      grp = {held, 8'h00};
      if (grp_pos != 2'd0) begin
        run[n]     = '{b64_of(grp[23:18]), 1'b0, 1'b0};
        run[n + 1] = '{b64_of(grp[17:12]), 1'b0, 1'b0};
        if (grp_pos == 2'd2) begin
          run[n + 2] = '{b64_of(grp[11:6]), 1'b0, 1'b0};
        end else begin
          run[n + 2] = '{PAD_CHAR, 1'b0, 1'b0};
        end
        run[n + 3] = '{PAD_CHAR, 1'b0, 1'b0};
        n += 4;
      end
      run[n] = '{BEL_CHAR, 1'b0, 1'b1};
      n++;
      grp_pos = 2'd0;
      held    = '0;
      in_msg  = 1'b0;
    end
    if (n > 0) run[n - 1].run_end = 1'b1;
    for (int i = 0; i < n; i++) want_chars.push_back(run[i]);
  endtask

  task automatic check_char();
    seq_char_t w;
    if (want_chars.size() == 0) begin
      $error("unexpected character %h with nothing pending", out_char);
      fail_count++;
      return;
    end
    w = want_chars.pop_front();
    chars_checked++;
    if (out_char !== w.ch) begin
      $error("out_char: expected %h, actual %h", w.ch, out_char);
      fail_count++;
    end
    if (run_last !== w.run_end) begin
      $error("run_last: expected %b, actual %b", w.run_end, run_last);
      fail_count++;
    end
    if (sequence_end !== w.seq_end) begin
      $error("sequence_end: expected %b, actual %b", w.seq_end, sequence_end);
      fail_count++;
    end
  endtask

  initial begin
    fail_count    = 0;
    chars_checked = 0;
    grp_pos       = '0;
    held          = '0;
    in_msg        = 1'b0;
  end

  // Predict before comparing: a byte never leaves in the cycle it arrives.
  always @(posedge clk) begin
    if (rst) begin
      want_chars.delete();
      grp_pos = '0;
      held    = '0;
      in_msg  = 1'b0;
    end else begin
      if (byte_valid && byte_ready) encode_byte(data_byte, final_byte);
      if (char_valid && char_ready) check_char();
    end
    chars_pending = want_chars.size();
  end

endmodule

@@ tb/osc52_base64_clipboard_framer_unit_tb.sv @@
// Top of the OSC 52 framer testbench: stimulus, idling, watchdog and verdict.
module osc52_base64_clipboard_framer_unit_tb;

  // Nothing accepted for this long means the block has hung.
  localparam int STALL_LIMIT  = 2000;
  // Cycles to keep watching the output after the last expected character.
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 105;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_ready;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       char_valid;
  logic       char_ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       sequence_end;

  int fail_count;
  int chars_pending;
  int chars_checked;

  // Percent of cycles in which each side holds off.
  int send_idle;
  int recv_idle;

  int bytes_sent;
  int msgs_sent;
  int stall_cycles;

  osc52_base64_clipboard_framer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .out_char     (out_char),
    .run_last     (run_last),
    .sequence_end (sequence_end)
  );

  osc52_seq_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .data_byte     (data_byte),
    .final_byte    (final_byte),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .out_char      (out_char),
    .run_last      (run_last),
    .sequence_end  (sequence_end),
    .fail_count    (fail_count),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: redraw ready on every falling edge, so stalls land on the prefix,
  // the group characters, the pads and the BEL alike.
  always @(negedge clk) begin
    if (rst) begin
      char_ready <= 1'b0;
    end else begin
      char_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (char_valid && char_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one byte. Call at a falling edge; return at the falling edge after
  // acceptance with valid still high, so a back-to-back byte never drops it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    if (fin) msgs_sent++;
    @(negedge clk);
  endtask

  // Send a whole message from a list of bytes; flag the last one.
  task automatic send_msg(input logic [7:0] body[$]);
    for (int i = 0; i < body.size(); i++) begin
      send_byte(body[i], i == body.size() - 1);
    end
  endtask

  // Random message: mostly short, now and then long enough for many groups.
  // Bias some bytes to the extremes so every sextet edge shows up.
  task automatic send_random_msg();
    logic [7:0] body[$];
    int         len;
    int         pick;
    if ($urandom_range(7) == 0) begin
      len = $urandom_range(9, 30);
    end else begin
      len = $urandom_range(1, 8);
    end
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        body.push_back(8'h00);
      end else if (pick == 1) begin
        body.push_back(8'hFF);
      end else begin
        body.push_back(8'($urandom));
      end
    end
    send_msg(body);
  endtask

  task automatic random_phase(input int s_idle, input int r_idle);
    int start;
    send_idle = s_idle;
    recv_idle = r_idle;
    start     = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) send_random_msg();
  endtask

  initial begin
    rst          = 1'b1;
    byte_valid   = 1'b0;
    data_byte    = 8'h00;
    final_byte   = 1'b0;
    char_ready   = 1'b0;
    send_idle    = 8;
    recv_idle    = 49;
    bytes_sent   = 0;
    msgs_sent    = 0;
    stall_cycles = 0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single-byte messages at both extremes (prefix, padded group
    // and BEL all from one byte), one and two held bytes at the end, a final
    // byte that completes a group, bytes that complete nothing, and groups
    // that hit the '+' and '/' ends of the alphabet.
    send_msg('{8'h00});
    send_msg('{8'hFF});
    send_msg('{8'h00, 8'hFF});
    send_msg('{8'hFF, 8'h00, 8'hAA});
    send_msg('{8'h55, 8'hAA, 8'h0F, 8'hF0});
    send_msg('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
    send_msg('{8'hFB, 8'hEF, 8'hBE, 8'hFF, 8'hFF, 8'hFF});

    // Random: sender idles lightly, receiver heavily; then swap; then none.
    random_phase(8, 49);
    random_phase(49, 8);
    random_phase(0, 0);

    byte_valid <= 1'b0;

    // Drain: wait out every expected character, then watch for strays.
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes in %0d messages, %0d characters compared.",
             bytes_sent, msgs_sent, chars_checked);
    $display("Idle mixes: sender/receiver 8/49 percent, 49/8 percent, none.");
    if (fail_count == 0 && chars_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
